// File: sv/dsst_pkg.sv
// Shared types and constants for the DMX switch servo timer.
// No dependencies; imported by dsst_chan_step and dmx_servo_switch_timer_top.
package dsst_pkg;

	// Channel count and field widths
	localparam int CHANNELS = 10;
	localparam int CH_W     = 4;
	localparam int LEVEL_W  = 8;
	localparam int TIME_W   = 32;
	localparam int DELAY_W  = 16;
	localparam int ANGLE_W  = 8;
	localparam int POS_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_FLOOR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD = 2'd2;

	// Configuration reset values
	localparam logic [DELAY_W-1:0] SETTLE_DELAY_RST = 16'd2500;
	localparam logic [LEVEL_W-1:0] OFF_FLOOR_RST    = 8'd2;
	localparam logic [LEVEL_W-1:0] ON_THRESHOLD_RST = 8'd127;

	// Switch positions
	localparam logic [POS_W-1:0] POS_NEUTRAL = 2'd0;
	localparam logic [POS_W-1:0] POS_ON      = 2'd1;
	localparam logic [POS_W-1:0] POS_OFF     = 2'd2;

	// Servo angles
	localparam logic [ANGLE_W-1:0] ANGLE_ON      = 8'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_NEUTRAL = 8'd90;
	localparam logic [ANGLE_W-1:0] ANGLE_OFF     = 8'd180;

	// Per-channel timer state; a deadline of zero is not armed
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [TIME_W-1:0] ret_dl;
		logic [TIME_W-1:0] hold_dl;
	} chan_state_t;

	// Live configuration
	typedef struct packed {
		logic [DELAY_W-1:0] settle_delay;
		logic [LEVEL_W-1:0] off_floor;
		logic [LEVEL_W-1:0] on_threshold;
	} cfg_t;

	// One result
	typedef struct packed {
		logic               write_valid;
		logic [ANGLE_W-1:0] angle;
		logic [POS_W-1:0]   pos;
	} step_res_t;

endpackage

// File: sv/dsst_chan_step.sv
// Next-state and result logic for one channel request of the switch servo timer.
// Depends on dsst_pkg.
module dsst_chan_step (
	input  dsst_pkg::chan_state_t           cur,
	input  dsst_pkg::cfg_t                  cfg,
	input  logic [dsst_pkg::LEVEL_W-1:0]    dmx_level,
	input  logic [dsst_pkg::TIME_W-1:0]     now_ms,
	output dsst_pkg::chan_state_t           nxt,
	output dsst_pkg::step_res_t             res
);
	import dsst_pkg::*;

	logic [TIME_W-1:0] deadline;
	logic              hold_exp;
	logic              ret_exp;
	logic [TIME_W-1:0] ret_t;
	logic [TIME_W-1:0] hold_t;
	logic [POS_W-1:0]  proposed;
	logic              move;

	// New deadline, wraps modulo 2^32
	assign deadline = now_ms + {{(TIME_W-DELAY_W){1'b0}}, cfg.settle_delay};

	// Timer step: hold-off elapsed clears both, else return elapsed goes neutral
	assign hold_exp = (cur.hold_dl != '0) && (cur.hold_dl < now_ms);
	assign ret_exp  = (cur.ret_dl != '0) && (cur.ret_dl < now_ms) && (cur.hold_dl == '0);

	always_comb begin
		ret_t  = cur.ret_dl;
		hold_t = cur.hold_dl;
		if (hold_exp) begin
			ret_t  = '0;
			hold_t = '0;
		end else if (ret_exp) begin
			hold_t = deadline;
		end
	end

	// Level classification
	always_comb begin
		if (dmx_level >= cfg.on_threshold) begin
			proposed = POS_ON;
		end else if (dmx_level > cfg.off_floor) begin
			proposed = POS_OFF;
		end else begin
			proposed = POS_NEUTRAL;
		end
	end

	assign move = (proposed != POS_NEUTRAL) && (proposed != cur.pos) && (ret_t == '0);

	// Merge timer and move outcomes
	always_comb begin
		nxt.pos     = cur.pos;
		nxt.ret_dl  = ret_t;
		nxt.hold_dl = hold_t;
		res.write_valid = 1'b0;
		res.angle       = '0;
		if (!hold_exp && ret_exp) begin
			res.write_valid = 1'b1;
			res.angle       = ANGLE_NEUTRAL;
		end
		if (move) begin
			nxt.pos         = proposed;
			nxt.ret_dl      = deadline;
			res.write_valid = 1'b1;
			res.angle       = (proposed == POS_ON) ? ANGLE_ON : ANGLE_OFF;
		end
		res.pos = nxt.pos;
	end

endmodule

// File: sv/dmx_servo_switch_timer_top.sv
// Top level of the DMX switch servo timer: request register, channel state, result register.
// Depends on dsst_pkg and dsst_chan_step.
//
// A request (channel, dmx_level, now_ms) is taken on any cycle that start is high;
// busy is always low, so one request per clock is sustained. Each request gives
// exactly one result, shown with done for one cycle: the request register captures
// the request, then the result register captures its result through the channel state logic.
// The receiver cannot stall; results must be taken as they appear. Requests to the
// same channel on consecutive cycles see each other's state updates. Channels at or
// above the channel count change nothing and report write_valid 0, angle 0, position
// neutral. Configuration writes (cfg_we, cfg_index, cfg_data) land at the edge that
// samples cfg_we; write only with no request in flight. Index 3 is ignored.
module dmx_servo_switch_timer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [dsst_pkg::CH_W-1:0]          channel,
	input  logic [dsst_pkg::LEVEL_W-1:0]       dmx_level,
	input  logic [dsst_pkg::TIME_W-1:0]        now_ms,
	input  logic                               cfg_we,
	input  logic [dsst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsst_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               done,
	output logic [dsst_pkg::CH_W-1:0]          channel_out,
	output logic                               write_valid,
	output logic [dsst_pkg::ANGLE_W-1:0]       angle_deg,
	output logic [dsst_pkg::POS_W-1:0]         position
);
	import dsst_pkg::*;

	cfg_t              cfg_q;
	chan_state_t       state_q [CHANNELS];

	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [TIME_W-1:0] now_s1;

	logic              in_range;
	chan_state_t       cur;
	chan_state_t       nxt;
	step_res_t         res;

	logic              done_q;
	logic [CH_W-1:0]   ch_q;
	step_res_t         res_q;

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_delay <= SETTLE_DELAY_RST;
			cfg_q.off_floor    <= OFF_FLOOR_RST;
			cfg_q.on_threshold <= ON_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE_DELAY: cfg_q.settle_delay <= cfg_data;
				REG_OFF_FLOOR:    cfg_q.off_floor    <= cfg_data[LEVEL_W-1:0];
				REG_ON_THRESHOLD: cfg_q.on_threshold <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ch_s1    <= channel;
			level_s1 <= dmx_level;
			now_s1   <= now_ms;
		end
	end

	// Channel state read
	assign in_range = (ch_s1 < CH_W'(CHANNELS));
	assign cur      = in_range ? state_q[ch_s1] : '0;

	dsst_chan_step u_step (
		.cur       (cur),
		.cfg       (cfg_q),
		.dmx_level (level_s1),
		.now_ms    (now_s1),
		.nxt       (nxt),
		.res       (res)
	);

	// Channel state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else if (valid_s1 && in_range) begin
			state_q[ch_s1] <= nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ch_q  <= ch_s1;
			res_q <= in_range ? res : '0;
		end
	end

	assign done        = done_q;
	assign channel_out = ch_q;
	assign write_valid = res_q.write_valid;
	assign angle_deg   = res_q.angle;
	assign position    = res_q.pos;

endmodule
